FILE: sv/owo_pkg.sv
`default_nettype none
package owo_pkg;

   // Widths of the shared multiply-divide unit
   localparam int unsigned MAG_W  = 35;  // numerator magnitude
   localparam int unsigned MULB_W = 36;  // second factor
   localparam int unsigned DEN_W  = 38;  // divisor
   localparam int unsigned QUO_W  = 34;  // quotient bits before rounding
   localparam int unsigned RES_W  = 36;  // signed rounded result

   // Scale factors: 65536e6/sqrt(3) and 65536e6
   localparam logic [MULB_W-1:0] KX_SCALE = 36'd37837227242;
   localparam logic [MULB_W-1:0] KY_SCALE = 36'd65536000000;
   localparam logic [DEN_W-1:0]  US_PER_SEC = 38'd1000000;

   // Angle constants in Q30
   localparam logic [47:0]        TWO_PI_Q30 = 48'd6746518852;
   localparam logic signed [34:0] TWO_PI_R   = 35'sd6746518852;
   localparam logic signed [34:0] PI_R       = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_R  = 35'sd1686629713;
   localparam logic signed [33:0] CORDIC_X0  = 34'sd652032874;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic [MAG_W-1:0]  a_mag;
      logic [MULB_W-1:0] b_mag;
      logic [DEN_W-1:0]  den;
   } md_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [RES_W-1:0] res;
   } md_rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] heading;
   } cd_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_q30;
      logic signed [31:0] sin_q30;
   } cd_rsp_type;

   // Arctangent of 2^-i in Q30, truncated
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/owo_muldiv.sv
`default_nettype none
module owo_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  owo_pkg::md_req_type md_req,
   output owo_pkg::md_rsp_type md_rsp
);
   import owo_pkg::*;

   localparam int unsigned PROD_W = MAG_W + MULB_W;
   localparam int unsigned CNT_W  = $clog2(MULB_W);

   typedef enum logic [4:0] {
      MD_IDLE = 5'b00001,
      MD_MUL  = 5'b00010,
      MD_CHK  = 5'b00100,
      MD_DIV  = 5'b01000,
      MD_RND  = 5'b10000
   } md_state_type;

   md_state_type            state_ff, state_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic                    ovf_ff, ovf_in;
   logic [MAG_W-1:0]        a_ff, a_in;
   logic [MULB_W-1:0]       b_ff, b_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [RES_W-1:0] res_ff, res_in;

   logic [DEN_W:0]   trial;
   logic             ge;
   logic             rnd_up;
   logic [MAG_W-1:0] mag;
   logic [RES_W-1:0] mag_ext;

   always_comb begin
      trial   = {rem_ff, prod_ff[QUO_W-1]};
      ge      = trial >= {1'b0, den_ff};
      rnd_up  = {rem_ff, 1'b0} >= {1'b0, den_ff};
      mag     = ovf_ff ? '1 : ({1'b0, quo_ff} + MAG_W'(rnd_up));
      mag_ext = {1'b0, mag};

      state_in = state_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;

      unique case (state_ff)
         MD_IDLE: begin
            // latch operands
            if (md_req.start) begin
               a_in     = md_req.a_mag;
               b_in     = md_req.b_mag;
               den_in   = md_req.den;
               neg_in   = md_req.neg;
               prod_in  = '0;
               cnt_in   = CNT_W'(MULB_W - 1);
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            // shift-add, one bit of the second factor a cycle
            prod_in = (prod_ff << 1) + PROD_W'(b_ff[MULB_W-1] ? a_ff : '0);
            b_in    = b_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = MD_CHK;
         end
         MD_CHK: begin
            // quotient too wide for the result: flag and saturate later
            ovf_in   = {1'b0, prod_ff[PROD_W-1:QUO_W]} >= den_ff;
            rem_in   = {1'b0, prod_ff[PROD_W-1:QUO_W]};
            quo_in   = '0;
            cnt_in   = CNT_W'(QUO_W - 1);
            state_in = MD_DIV;
         end
         MD_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            quo_in  = {quo_ff[QUO_W-2:0], ge};
            prod_in = prod_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = MD_RND;
         end
         MD_RND: begin
            // round half away from zero, then apply sign
            res_in   = neg_ff ? -$signed(mag_ext) : $signed(mag_ext);
            done_in  = 1'b1;
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.res  = res_ff;

endmodule
`default_nettype wire

FILE: sv/owo_cordic.sv
`default_nettype none
module owo_cordic #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  owo_pkg::cd_req_type cd_req,
   output owo_pkg::cd_rsp_type cd_rsp
);
   import owo_pkg::*;

   localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [3:0]  RED_TOP = 4'd13;

   typedef enum logic [3:0] {
      CD_IDLE = 4'b0001,
      CD_RED  = 4'b0010,
      CD_FOLD = 4'b0100,
      CD_ROT  = 4'b1000
   } cd_state_type;

   cd_state_type       state_ff, state_in;
   logic               done_ff, done_in;
   logic [47:0]        v_ff, v_in;
   logic [3:0]         red_ff, red_in;
   logic signed [34:0] r_ff, r_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic               flip_ff, flip_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic signed [31:0] cos_ff, cos_in;
   logic signed [31:0] sin_ff, sin_in;

   logic [47:0]        head_ext;
   logic [47:0]        sub;
   logic signed [34:0] r0;
   logic signed [34:0] r1;
   logic signed [33:0] xs;
   logic signed [33:0] ys;
   logic signed [33:0] x_nx;
   logic signed [33:0] y_nx;
   logic signed [34:0] at;

   always_comb begin
      head_ext = {{16{cd_req.heading[31]}}, cd_req.heading};
      sub      = TWO_PI_Q30 << red_ff;
      r0       = $signed({1'b0, v_ff[33:0]});
      r1       = (r0 > PI_R) ? (r0 - TWO_PI_R) : r0;
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      at       = $signed({3'b000, atan_q30(5'(step_ff))});
      if (!r_ff[34]) begin
         x_nx = x_ff - ys;
         y_nx = y_ff + xs;
      end else begin
         x_nx = x_ff + ys;
         y_nx = y_ff - xs;
      end

      state_in = state_ff;
      done_in  = 1'b0;
      v_in     = v_ff;
      red_in   = red_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      flip_in  = flip_ff;
      step_in  = step_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;

      unique case (state_ff)
         CD_IDLE: begin
            // offset by a multiple of 2*pi so the angle is never negative
            if (cd_req.start) begin
               v_in     = (head_ext << 14) + (TWO_PI_Q30 << RED_TOP);
               red_in   = RED_TOP;
               state_in = CD_RED;
            end
         end
         CD_RED: begin
            // reduce modulo 2*pi, one shifted compare a cycle
            if (v_ff >= sub) v_in = v_ff - sub;
            red_in = red_ff - 1'b1;
            if (red_ff == '0) state_in = CD_FOLD;
         end
         CD_FOLD: begin
            // map to [-pi/2, pi/2] and remember the sign flip
            if (r1 > HALF_PI_R) begin
               r_in    = r1 - PI_R;
               flip_in = 1'b1;
            end else if (r1 < -HALF_PI_R) begin
               r_in    = r1 + PI_R;
               flip_in = 1'b1;
            end else begin
               r_in    = r1;
               flip_in = 1'b0;
            end
            x_in     = CORDIC_X0;
            y_in     = '0;
            step_in  = '0;
            state_in = CD_ROT;
         end
         CD_ROT: begin
            // one rotation step a cycle
            x_in    = x_nx;
            y_in    = y_nx;
            r_in    = r_ff[34] ? (r_ff + at) : (r_ff - at);
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               cos_in   = flip_ff ? -x_nx[31:0] : x_nx[31:0];
               sin_in   = flip_ff ? -y_nx[31:0] : y_nx[31:0];
               done_in  = 1'b1;
               state_in = CD_IDLE;
            end
         end
         default: state_in = CD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      red_ff  <= red_in;
      r_ff    <= r_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      flip_ff <= flip_in;
      step_ff <= step_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign cd_rsp.done    = done_ff;
   assign cd_rsp.cos_q30 = cos_ff;
   assign cd_rsp.sin_q30 = sin_ff;

endmodule
`default_nettype wire

FILE: sv/omni_wheel_odometry_unit.sv
`default_nettype none
// Channel   Direction  Ports                 Contents
// req       in         req_t*                encoder sample or relative-pose clear
// rsp       out        rsp_t*                poses, velocities, moved flag
// csr       in         csr_we/index/wdata    count scales, write only
//
// A sample that moved takes eight passes of the serial multiply-divide unit plus two
// CORDIC runs; a clear item and a sample with no count change skip both units.
// Reset is synchronous; it restores the scale registers and zeroes all pose state.
// A new word is taken once the previous result sits in the output register;
// a stalled output only holds the block when the next result is ready.
module omni_wheel_odometry_unit #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,   // wheel_count_a, wheel_count_b, wheel_count_c, elapsed_us
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // pose_x, pose_y, heading, vel_x, vel_y, vel_turn,
                                     // rel_x, rel_y, rel_heading
   output logic         rsp_tuser,   // moved
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   import owo_pkg::*;

   localparam logic CSR_LIN  = 1'b0;
   localparam logic CSR_TURN = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_PREP      = 9'b000000010,
      ST_CORD_GO   = 9'b000000100,
      ST_CORD_WAIT = 9'b000001000,
      ST_ROT       = 9'b000010000,
      ST_DIV_GO    = 9'b000100000,
      ST_DIV_WAIT  = 9'b001000000,
      ST_UPDATE    = 9'b010000000,
      ST_OUT       = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      JOB_DX, JOB_DY, JOB_VX, JOB_VY, JOB_VZ, JOB_DT
   } job_type;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic      pose_ff, pose_in;
   logic [2:0] rot_ff, rot_in;
   logic [15:0] klin_ff, klin_in;
   logic [15:0] kturn_ff, kturn_in;

   logic signed [31:0] prev_ff [3];
   logic signed [31:0] prev_in [3];
   logic signed [31:0] absp_ff [3];
   logic signed [31:0] absp_in [3];
   logic signed [31:0] relp_ff [3];
   logic signed [31:0] relp_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic signed [31:0] cnt_ff [3];
   logic signed [31:0] cnt_in [3];
   logic signed [31:0] vnew_ff [3];
   logic signed [31:0] vnew_in [3];
   logic signed [RES_W-1:0] dx_ff [2];
   logic signed [RES_W-1:0] dx_in [2];
   logic signed [RES_W-1:0] dy_ff [2];
   logic signed [RES_W-1:0] dy_in [2];

   logic [19:0]             us_ff, us_in;
   logic signed [34:0]      nx_ff, nx_in;
   logic signed [34:0]      ny_ff, ny_in;
   logic signed [34:0]      nz_ff, nz_in;
   logic [DEN_W-1:0]        denl_ff, denl_in;
   logic [DEN_W-1:0]        denl3_ff, denl3_in;
   logic [DEN_W-1:0]        dent3_ff, dent3_in;
   logic signed [31:0]      c_ff, c_in;
   logic signed [31:0]      s_ff, s_in;
   logic signed [63:0]      mul_ff, mul_in;
   logic signed [64:0]      acc_ff, acc_in;
   logic signed [33:0]      ra_ff, ra_in;
   logic signed [33:0]      rb_ff, rb_in;
   logic signed [RES_W-1:0] dth_ff, dth_in;
   logic                    moved_ff, moved_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [287:0]            rsp_data_ff, rsp_data_in;
   logic                    rsp_moved_ff, rsp_moved_in;

   md_req_type md_req;
   md_rsp_type md_rsp;
   cd_req_type cd_req;
   cd_rsp_type cd_rsp;

   logic signed [32:0] d0, d1, d2;
   logic signed [34:0] d0e, d1e, d2e;
   logic               any_move;
   logic [15:0]        kl, kt;
   logic [35:0]        pl, pt;
   logic signed [31:0] opa, opb;
   logic signed [34:0] num;
   logic [19:0]        us_raw;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > 37'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -37'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // round(v / 2^30), halves away from zero
   function automatic logic signed [33:0] rnd30(input logic signed [64:0] v);
      logic [64:0] mag;
      logic [64:0] q;
      mag = v[64] ? 65'(-v) : 65'(v);
      q = (mag + 65'd536870912) >> 30;
      return v[64] ? -$signed(q[33:0]) : $signed(q[33:0]);
   endfunction

   function automatic logic signed [36:0] ext_res(input logic signed [RES_W-1:0] v);
      return {v[RES_W-1], v};
   endfunction

   function automatic logic signed [36:0] ext32(input logic signed [31:0] v);
      return {{5{v[31]}}, v};
   endfunction

   owo_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   owo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cd_req (cd_req),
      .cd_rsp (cd_rsp)
   );

   // Deltas, movement test and scale products
   always_comb begin
      d0  = {cnt_ff[0][31], cnt_ff[0]} - {prev_ff[0][31], prev_ff[0]};
      d1  = {cnt_ff[1][31], cnt_ff[1]} - {prev_ff[1][31], prev_ff[1]};
      d2  = {cnt_ff[2][31], cnt_ff[2]} - {prev_ff[2][31], prev_ff[2]};
      d0e = {{2{d0[32]}}, d0};
      d1e = {{2{d1[32]}}, d1};
      d2e = {{2{d2[32]}}, d2};
      any_move = (cnt_ff[0] != prev_ff[0]) || (cnt_ff[1] != prev_ff[1]) ||
                 (cnt_ff[2] != prev_ff[2]);
      kl = (klin_ff == '0) ? 16'd1 : klin_ff;
      kt = (kturn_ff == '0) ? 16'd1 : kturn_ff;
      pl = {16'b0, us_ff} * {20'b0, kl};
      pt = {16'b0, us_ff} * {20'b0, kt};
   end

   // Rotation multiplier operands
   always_comb begin
      case (rot_ff)
         3'd1:    begin opa = vel_ff[1]; opb = s_ff; end
         3'd2:    begin opa = vel_ff[0]; opb = s_ff; end
         3'd3:    begin opa = vel_ff[1]; opb = c_ff; end
         default: begin opa = vel_ff[0]; opb = c_ff; end
      endcase
   end

   // Shared unit and CORDIC operands
   always_comb begin
      md_req.start = (state_ff == ST_DIV_GO);
      unique case (job_ff)
         JOB_DX: begin
            num = {ra_ff[33], ra_ff};
            md_req.b_mag = {16'b0, us_ff};
            md_req.den   = US_PER_SEC;
         end
         JOB_DY: begin
            num = {rb_ff[33], rb_ff};
            md_req.b_mag = {16'b0, us_ff};
            md_req.den   = US_PER_SEC;
         end
         JOB_VX: begin
            num = nx_ff;
            md_req.b_mag = KX_SCALE;
            md_req.den   = denl_ff;
         end
         JOB_VY: begin
            num = ny_ff;
            md_req.b_mag = KY_SCALE;
            md_req.den   = denl3_ff;
         end
         JOB_VZ: begin
            num = nz_ff;
            md_req.b_mag = KY_SCALE;
            md_req.den   = dent3_ff;
         end
         JOB_DT: begin
            num = {{3{vnew_ff[2][31]}}, vnew_ff[2]};
            md_req.b_mag = {16'b0, us_ff};
            md_req.den   = US_PER_SEC;
         end
         default: begin
            num = '0;
            md_req.b_mag = '0;
            md_req.den   = US_PER_SEC;
         end
      endcase
      md_req.neg   = num[34];
      md_req.a_mag = num[34] ? MAG_W'(-num) : MAG_W'(num);

      cd_req.start   = (state_ff == ST_CORD_GO);
      cd_req.heading = pose_ff ? relp_ff[2] : absp_ff[2];
   end

   assign us_raw = req_tdata[115:96];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pose_in      = pose_ff;
      rot_in       = rot_ff;
      klin_in      = klin_ff;
      kturn_in     = kturn_ff;
      prev_in      = prev_ff;
      absp_in      = absp_ff;
      relp_in      = relp_ff;
      vel_in       = vel_ff;
      cnt_in       = cnt_ff;
      vnew_in      = vnew_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      us_in        = us_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      denl_in      = denl_ff;
      denl3_in     = denl3_ff;
      dent3_in     = dent3_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      dth_in       = dth_ff;
      moved_in     = moved_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_moved_in = rsp_moved_ff;
      req_tready   = (state_ff == ST_IDLE);

      // scale registers
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIN:  klin_in  = csr_wdata;
            CSR_TURN: kturn_in = csr_wdata;
            default:  klin_in  = klin_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  relp_in  = '{default: '0};
                  moved_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  cnt_in[0] = req_tdata[31:0];
                  cnt_in[1] = req_tdata[63:32];
                  cnt_in[2] = req_tdata[95:64];
                  us_in     = (us_raw == '0) ? 20'd1 : us_raw;
                  state_in  = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            nx_in    = d1e - d0e;
            ny_in    = d0e + d1e - (d2e <<< 1);
            nz_in    = d0e + d1e + d2e;
            denl_in  = {2'b0, pl};
            denl3_in = {2'b0, pl} + {1'b0, pl, 1'b0};
            dent3_in = {2'b0, pt} + {1'b0, pt, 1'b0};
            pose_in  = 1'b0;
            moved_in = 1'b0;
            state_in = any_move ? ST_CORD_GO : ST_OUT;
         end
         ST_CORD_GO: state_in = ST_CORD_WAIT;
         ST_CORD_WAIT: begin
            if (cd_rsp.done) begin
               c_in     = cd_rsp.cos_q30;
               s_in     = cd_rsp.sin_q30;
               rot_in   = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            // rotate the previous velocity by the heading
            mul_in = opa * opb;
            rot_in = rot_ff + 1'b1;
            case (rot_ff)
               3'd1: acc_in = {mul_ff[63], mul_ff};
               3'd2: acc_in = acc_ff - {mul_ff[63], mul_ff};
               3'd3: begin
                  ra_in  = rnd30(acc_ff);
                  acc_in = {mul_ff[63], mul_ff};
               end
               3'd4: acc_in = acc_ff + {mul_ff[63], mul_ff};
               3'd5: begin
                  rb_in    = rnd30(acc_ff);
                  job_in   = JOB_DX;
                  state_in = ST_DIV_GO;
               end
               default: acc_in = acc_ff;
            endcase
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (md_rsp.done) begin
               state_in = ST_DIV_GO;
               unique case (job_ff)
                  JOB_DX: begin
                     dx_in[pose_ff] = md_rsp.res;
                     job_in = JOB_DY;
                  end
                  JOB_DY: begin
                     dy_in[pose_ff] = md_rsp.res;
                     if (!pose_ff) begin
                        pose_in  = 1'b1;
                        job_in   = JOB_DX;
                        state_in = ST_CORD_GO;
                     end else begin
                        job_in = JOB_VX;
                     end
                  end
                  JOB_VX: begin
                     vnew_in[0] = sat32(ext_res(md_rsp.res));
                     job_in = JOB_VY;
                  end
                  JOB_VY: begin
                     vnew_in[1] = sat32(ext_res(md_rsp.res));
                     job_in = JOB_VZ;
                  end
                  JOB_VZ: begin
                     vnew_in[2] = sat32(ext_res(md_rsp.res));
                     job_in = JOB_DT;
                  end
                  JOB_DT: begin
                     dth_in   = md_rsp.res;
                     state_in = ST_UPDATE;
                  end
                  default: state_in = ST_UPDATE;
               endcase
            end
         end
         ST_UPDATE: begin
            // advance both poses, commit velocity and counts
            absp_in[0] = sat32(ext32(absp_ff[0]) + ext_res(dx_ff[0]));
            absp_in[1] = sat32(ext32(absp_ff[1]) + ext_res(dy_ff[0]));
            absp_in[2] = sat32(ext32(absp_ff[2]) + ext_res(dth_ff));
            relp_in[0] = sat32(ext32(relp_ff[0]) + ext_res(dx_ff[1]));
            relp_in[1] = sat32(ext32(relp_ff[1]) + ext_res(dy_ff[1]));
            relp_in[2] = sat32(ext32(relp_ff[2]) + ext_res(dth_ff));
            vel_in   = vnew_ff;
            prev_in  = cnt_ff;
            moved_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand the word to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {relp_ff[2], relp_ff[1], relp_ff[0],
                               vel_ff[2], vel_ff[1], vel_ff[0],
                               absp_ff[2], absp_ff[1], absp_ff[0]};
               rsp_moved_in = moved_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         klin_ff      <= 16'd9100;
         kturn_ff     <= 16'd1840;
         prev_ff      <= '{default: '0};
         absp_ff      <= '{default: '0};
         relp_ff      <= '{default: '0};
         vel_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         klin_ff      <= klin_in;
         kturn_ff     <= kturn_in;
         prev_ff      <= prev_in;
         absp_ff      <= absp_in;
         relp_ff      <= relp_in;
         vel_ff       <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      pose_ff      <= pose_in;
      rot_ff       <= rot_in;
      cnt_ff       <= cnt_in;
      vnew_ff      <= vnew_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      us_ff        <= us_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      nz_ff        <= nz_in;
      denl_ff      <= denl_in;
      denl3_ff     <= denl3_in;
      dent3_ff     <= dent3_in;
      c_ff         <= c_in;
      s_ff         <= s_in;
      mul_ff       <= mul_in;
      acc_ff       <= acc_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      dth_ff       <= dth_in;
      moved_ff     <= moved_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_moved_ff <= rsp_moved_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_moved_ff;

endmodule
`default_nettype wire
